>>> hw/rtl/mer_pkg.sv
// Shared constants, types and codes for the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package mer_pkg;

    localparam int COORD_BITS = 12;
    localparam int OUT_W      = COORD_BITS + 2;       // signed output coordinates
    localparam int SQ_W       = 2 * COORD_BITS;       // radius squared
    localparam int TSQ_W      = SQ_W + 1;             // twice radius squared
    localparam int MB_W       = COORD_BITS + 2;       // signed multiplier b operand
    localparam int PROD_W     = TSQ_W + MB_W;         // signed product
    localparam int ERR_W      = 3 * COORD_BITS + 8;   // error and step terms
    localparam int STOP_W     = 3 * COORD_BITS + 4;   // region stop terms
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X  = 2'd0,
        REG_CENTER_Y  = 2'd1,
        REG_FILL_MODE = 2'd2
    } cfg_index_t;

    // One multiplication per set-up cycle.
    typedef enum logic [2:0] {
        MUL_NONE   = 3'd0,
        MUL_RX_SQ  = 3'd1,
        MUL_RY_SQ  = 3'd2,
        MUL_STEP_X = 3'd3,
        MUL_STOP_X = 3'd4,
        MUL_STEP_Y = 3'd5,
        MUL_STOP_Y = 3'd6
    } mul_op_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RX_SQ  = 8'b0000_0010,
        ST_RY_SQ  = 8'b0000_0100,
        ST_STEP_X = 8'b0000_1000,
        ST_STOP_X = 8'b0001_0000,
        ST_STEP_Y = 8'b0010_0000,
        ST_STOP_Y = 8'b0100_0000,
        ST_RUN    = 8'b1000_0000
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    tick;
        mul_op_t mul_op;
    } dp_cmd_t;

    typedef struct packed {
        logic last_tick;
    } dp_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/midpoint_ellipse_rasterizer.sv
// A tick word's group is written into the output register in the cycle after the word is accepted.
// Throughput: one tick word and one group per cycle while the output side keeps up.
// A start word is a load followed by six steps of the shared set-up multiplier;
// no input word is accepted during the six multiplier steps.
// Reset (aresetn low at a clock edge) clears the center, fill mode, state and output valid.
`timescale 1ns / 1ps
`default_nettype none
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [COORD_BITS-1:0]   cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_start_req,
    input  wire logic [COORD_BITS-1:0]   s_corner_x,
    input  wire logic [COORD_BITS-1:0]   s_corner_y,
    input  wire logic                    s_pen_set,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [OUT_W-1:0]      m_x_left,
    output logic signed [OUT_W-1:0]      m_x_right,
    output logic signed [OUT_W-1:0]      m_y_upper,
    output logic signed [OUT_W-1:0]      m_y_lower,
    output logic                         m_pixel_value,
    output logic                         m_is_span,
    output logic                         m_last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mer_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .start_req (s_start_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mer_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .corner_x    (s_corner_x),
        .corner_y    (s_corner_y),
        .pen_set     (s_pen_set),
        .x_left      (m_x_left),
        .x_right     (m_x_right),
        .y_upper     (m_y_upper),
        .y_lower     (m_y_lower),
        .pixel_value (m_pixel_value),
        .is_span     (m_is_span),
        .last        (m_last)
    );

endmodule
`default_nettype wire

>>> hw/rtl/mer_datapath.sv
// Datapath: configuration registers, set-up multiplier and per-tick midpoint stepping.
`timescale 1ns / 1ps
`default_nettype none
module mer_datapath
    import mer_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [COORD_BITS-1:0]        cfg_data,
    input  wire dp_cmd_t                      cmd,
    output dp_status_t                        status,
    input  wire logic [COORD_BITS-1:0]        corner_x,
    input  wire logic [COORD_BITS-1:0]        corner_y,
    input  wire logic                         pen_set,
    output logic signed [OUT_W-1:0]           x_left,
    output logic signed [OUT_W-1:0]           x_right,
    output logic signed [OUT_W-1:0]           y_upper,
    output logic signed [OUT_W-1:0]           y_lower,
    output logic                              pixel_value,
    output logic                              is_span,
    output logic                              last
);

    logic [COORD_BITS-1:0]     center_x_reg, center_y_reg;
    logic                      fill_mode_reg;
    logic [COORD_BITS-1:0]     radius_x_reg, radius_y_reg;
    logic                      pen_reg;
    logic [SQ_W-1:0]           a_sq_reg, b_sq_reg;
    logic [OUT_W-1:0]          x_off_reg, y_off_reg;
    logic signed [ERR_W-1:0]   step_x_reg, step_y_reg, err_reg, step_y2_reg;
    logic signed [STOP_W-1:0]  stop_x_reg, stop_y_reg, stop_y2_reg;
    logic                      region2_reg;

    logic [OUT_W-1:0]          x_off_next, y_off_next;
    logic signed [ERR_W-1:0]   step_x_next, step_y_next, err_next;
    logic signed [STOP_W-1:0]  stop_x_next, stop_y_next;
    logic                      region2_next;

    // Radii from the corner, forced to at least one.
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0]      abs_dx, abs_dy, rad_x, rad_y;

    always_comb begin
        dx = $signed({1'b0, corner_x}) - $signed({1'b0, center_x_reg});
        dy = $signed({1'b0, corner_y}) - $signed({1'b0, center_y_reg});
        abs_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        rad_x = (abs_dx == '0) ? COORD_BITS'(1) : abs_dx;
        rad_y = (abs_dy == '0) ? COORD_BITS'(1) : abs_dy;
    end

    // Shared set-up multiplier.
    logic [SQ_W-1:0]           mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [TSQ_W-1:0]   mul_a_s;
    logic signed [PROD_W-1:0]  prod;

    always_comb begin
        case (cmd.mul_op)
            MUL_RX_SQ: begin
                mul_a = SQ_W'(radius_x_reg);
                mul_b = $signed({2'b00, radius_x_reg});
            end
            MUL_RY_SQ: begin
                mul_a = SQ_W'(radius_y_reg);
                mul_b = $signed({2'b00, radius_y_reg});
            end
            MUL_STEP_X: begin
                mul_a = b_sq_reg;
                mul_b = $signed(MB_W'(1)) - $signed({1'b0, radius_x_reg, 1'b0});
            end
            MUL_STOP_X: begin
                mul_a = b_sq_reg;
                mul_b = $signed({2'b00, radius_x_reg});
            end
            MUL_STEP_Y: begin
                mul_a = a_sq_reg;
                mul_b = $signed(MB_W'(1)) - $signed({1'b0, radius_y_reg, 1'b0});
            end
            MUL_STOP_Y: begin
                mul_a = a_sq_reg;
                mul_b = $signed({2'b00, radius_y_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_a_s = $signed({1'b0, mul_a});
        prod    = mul_a_s * mul_b;
    end

    // Twice the squared radii, widened for the error and stop arithmetic.
    logic signed [ERR_W-1:0]  tsa_e, tsb_e;
    logic signed [STOP_W-1:0] tsa_s, tsb_s;
    logic signed [ERR_W-1:0]  err_mid;
    logic signed [ERR_W:0]    test;
    logic                     take_diag;

    always_comb begin
        tsa_e = $signed(ERR_W'({a_sq_reg, 1'b0}));
        tsb_e = $signed(ERR_W'({b_sq_reg, 1'b0}));
        tsa_s = $signed(STOP_W'({a_sq_reg, 1'b0}));
        tsb_s = $signed(STOP_W'({b_sq_reg, 1'b0}));

        x_off_next   = x_off_reg;
        y_off_next   = y_off_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        stop_x_next  = stop_x_reg;
        stop_y_next  = stop_y_reg;
        region2_next = region2_reg;
        status.last_tick = 1'b0;

        if (!region2_reg) begin
            // Region one: y always steps, x steps when the midpoint is outside.
            err_mid   = err_reg + step_y_reg;
            test      = $signed({err_mid, 1'b0}) + $signed({step_x_reg[ERR_W-1], step_x_reg});
            take_diag = !test[ERR_W] && (test != '0);
            y_off_next  = y_off_reg + OUT_W'(1);
            stop_y_next = stop_y_reg + tsa_s;
            step_y_next = step_y_reg + tsa_e;
            err_next    = err_mid;
            if (take_diag) begin
                x_off_next  = x_off_reg - OUT_W'(1);
                stop_x_next = stop_x_reg - tsb_s;
                err_next    = err_mid + step_x_reg;
                step_x_next = step_x_reg + tsb_e;
            end
            if (!(stop_x_next >= stop_y_next)) begin
                region2_next = 1'b1;
                x_off_next   = '0;
                y_off_next   = OUT_W'(radius_y_reg);
                step_x_next  = $signed(ERR_W'(b_sq_reg));
                step_y_next  = step_y2_reg;
                err_next     = '0;
                stop_x_next  = '0;
                stop_y_next  = stop_y2_reg;
            end
        end else begin
            // Region two: x always steps, y steps when the midpoint is outside.
            err_mid   = err_reg + step_x_reg;
            test      = $signed({err_mid, 1'b0}) + $signed({step_y_reg[ERR_W-1], step_y_reg});
            take_diag = !test[ERR_W] && (test != '0);
            x_off_next  = x_off_reg + OUT_W'(1);
            stop_x_next = stop_x_reg + tsb_s;
            step_x_next = step_x_reg + tsb_e;
            err_next    = err_mid;
            if (take_diag) begin
                y_off_next  = y_off_reg - OUT_W'(1);
                stop_y_next = stop_y_reg - tsa_s;
                err_next    = err_mid + step_y_reg;
                step_y_next = step_y_reg + tsa_e;
            end
            if (!(stop_x_next <= stop_y_next)) begin
                status.last_tick = 1'b1;
                region2_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            fill_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CENTER_X:  center_x_reg  <= cfg_data;
                REG_CENTER_Y:  center_y_reg  <= cfg_data;
                REG_FILL_MODE: fill_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region2_reg <= 1'b0;
        end else if (cmd.load) begin
            region2_reg <= 1'b0;
        end else if (cmd.tick) begin
            region2_reg <= region2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            radius_x_reg <= rad_x;
            radius_y_reg <= rad_y;
            pen_reg      <= pen_set;
        end
        case (cmd.mul_op)
            MUL_RX_SQ:  a_sq_reg <= prod[SQ_W-1:0];
            MUL_RY_SQ: begin
                b_sq_reg   <= prod[SQ_W-1:0];
                // Region one start point; a_sq_reg is ready by now.
                x_off_reg  <= OUT_W'(radius_x_reg);
                y_off_reg  <= '0;
                step_y_reg <= $signed(ERR_W'(a_sq_reg));
                err_reg    <= '0;
                stop_y_reg <= '0;
            end
            MUL_STEP_X: step_x_reg  <= $signed({{(ERR_W-PROD_W){prod[PROD_W-1]}}, prod});
            MUL_STOP_X: stop_x_reg  <= $signed({prod, 1'b0});
            MUL_STEP_Y: step_y2_reg <= $signed({{(ERR_W-PROD_W){prod[PROD_W-1]}}, prod});
            MUL_STOP_Y: stop_y2_reg <= $signed({prod, 1'b0});
            default: ;
        endcase
        if (cmd.tick) begin
            x_off_reg   <= x_off_next;
            y_off_reg   <= y_off_next;
            step_x_reg  <= step_x_next;
            step_y_reg  <= step_y_next;
            err_reg     <= err_next;
            stop_x_reg  <= stop_x_next;
            stop_y_reg  <= stop_y_next;
            x_left      <= $signed(OUT_W'(center_x_reg)) - $signed(x_off_reg);
            x_right     <= $signed(OUT_W'(center_x_reg)) + $signed(x_off_reg);
            y_upper     <= $signed(OUT_W'(center_y_reg)) - $signed(y_off_reg);
            y_lower     <= $signed(OUT_W'(center_y_reg)) + $signed(y_off_reg);
            pixel_value <= pen_reg;
            is_span     <= fill_mode_reg;
            last        <= status.last_tick;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/mer_ctrl.sv
// Controller: set-up sequence, run state and the input and output handshakes.
`timescale 1ns / 1ps
`default_nettype none
module mer_ctrl
    import mer_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       start_req,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        accept;

    always_comb begin
        // A tick in the run state needs room in the output register.
        s_ready = (state_reg == ST_IDLE) ||
                  ((state_reg == ST_RUN) && (!m_valid_reg || m_ready));
        accept   = s_valid && s_ready;
        cmd.load = accept && start_req;
        cmd.tick = accept && !start_req && (state_reg == ST_RUN);

        case (state_reg)
            ST_RX_SQ:  cmd.mul_op = MUL_RX_SQ;
            ST_RY_SQ:  cmd.mul_op = MUL_RY_SQ;
            ST_STEP_X: cmd.mul_op = MUL_STEP_X;
            ST_STOP_X: cmd.mul_op = MUL_STOP_X;
            ST_STEP_Y: cmd.mul_op = MUL_STEP_Y;
            ST_STOP_Y: cmd.mul_op = MUL_STOP_Y;
            default:   cmd.mul_op = MUL_NONE;
        endcase

        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) state_next = ST_RX_SQ;
            end
            ST_RX_SQ:  state_next = ST_RY_SQ;
            ST_RY_SQ:  state_next = ST_STEP_X;
            ST_STEP_X: state_next = ST_STOP_X;
            ST_STOP_X: state_next = ST_STEP_Y;
            ST_STEP_Y: state_next = ST_STOP_Y;
            ST_STOP_Y: state_next = ST_RUN;
            ST_RUN: begin
                if (cmd.load) begin
                    state_next = ST_RX_SQ;
                end else if (cmd.tick && status.last_tick) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.tick) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
        m_valid = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> dv/midpoint_ellipse_rasterizer_tb.sv
// Self-checking testbench for the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
module midpoint_ellipse_rasterizer_tb;
    import mer_pkg::*;

    localparam int RUN_TO_END  = 1 << 30;
    localparam int WORD_TARGET = 1600;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    typedef logic signed [OUT_W-1:0] coord_t;

    typedef struct packed {
        coord_t x_left;
        coord_t x_right;
        coord_t y_upper;
        coord_t y_lower;
        logic   pixel_value;
        logic   is_span;
        logic   last;
    } pixel_group_t;

    // Tracks the ellipse walk and holds the groups the block still owes us.
    class ellipse_scoreboard;
        pixel_group_t          expected_groups[$];
        int unsigned           mismatches;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic                  fill_mode;
        bit                    running;
        bit                    in_region_two;
        bit                    pen;
        longint                x_off, y_off, rad_x, rad_y, two_a_sq, two_b_sq;
        longint                step_x, step_y, error_acc, stop_x, stop_y;

        function new();
            mismatches    = 0;
            center_x      = '0;
            center_y      = '0;
            fill_mode     = 1'b0;
            running       = 0;
            in_region_two = 0;
            pen           = 0;
            x_off         = 0;
            y_off         = 0;
            rad_x         = 0;
            rad_y         = 0;
            two_a_sq      = 0;
            two_b_sq      = 0;
            step_x        = 0;
            step_y        = 0;
            error_acc     = 0;
            stop_x        = 0;
            stop_y        = 0;
        endfunction

        function void write_register(cfg_index_t index, logic [COORD_BITS-1:0] data);
            case (index)
                REG_CENTER_X:  center_x = data;
                REG_CENTER_Y:  center_y = data;
                REG_FILL_MODE: fill_mode = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_groups.size();
        endfunction

        function void accept_word(logic start, logic [COORD_BITS-1:0] corner_x,
                                  logic [COORD_BITS-1:0] corner_y, logic pen_in);
            longint       cx;
            longint       cy;
            longint       dx;
            longint       dy;
            pixel_group_t grp;
            cx = longint'(center_x);
            cy = longint'(center_y);
            if (start) begin
                dx = longint'(corner_x) - cx;
                dy = longint'(corner_y) - cy;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                rad_x         = (dx < 1) ? 1 : dx;
                rad_y         = (dy < 1) ? 1 : dy;
                two_a_sq      = 2 * rad_x * rad_x;
                two_b_sq      = 2 * rad_y * rad_y;
                x_off         = rad_x;
                y_off         = 0;
                step_x        = rad_y * rad_y * (1 - 2 * rad_x);
                step_y        = rad_x * rad_x;
                error_acc     = 0;
                stop_x        = two_b_sq * rad_x;
                stop_y        = 0;
                pen           = pen_in;
                in_region_two = 0;
                running       = 1;
                return;
            end
            if (!running) return;

            grp.x_left      = coord_t'(cx - x_off);
            grp.x_right     = coord_t'(cx + x_off);
            grp.y_upper     = coord_t'(cy - y_off);
            grp.y_lower     = coord_t'(cy + y_off);
            grp.pixel_value = pen;
            grp.is_span     = fill_mode;
            grp.last        = 1'b0;

            if (!in_region_two) begin
                y_off++;
                stop_y    += two_a_sq;
                error_acc += step_y;
                step_y    += two_a_sq;
                if (2 * error_acc + step_x > 0) begin
                    x_off--;
                    stop_x    -= two_b_sq;
                    error_acc += step_x;
                    step_x    += two_b_sq;
                end
                // Slope passed -1: restart from the top of the ellipse, stepping x.
                if (stop_x < stop_y) begin
                    in_region_two = 1;
                    x_off         = 0;
                    y_off         = rad_y;
                    step_x        = rad_y * rad_y;
                    step_y        = rad_x * rad_x * (1 - 2 * rad_y);
                    error_acc     = 0;
                    stop_x        = 0;
                    stop_y        = two_a_sq * rad_y;
                end
            end else begin
                x_off++;
                stop_x    += two_b_sq;
                error_acc += step_x;
                step_x    += two_b_sq;
                if (2 * error_acc + step_y > 0) begin
                    y_off--;
                    stop_y    -= two_a_sq;
                    error_acc += step_y;
                    step_y    += two_a_sq;
                end
                if (stop_x > stop_y) begin
                    grp.last      = 1'b1;
                    running       = 0;
                    in_region_two = 0;
                end
            end
            expected_groups.push_back(grp);
        endfunction

        function void compare_group(pixel_group_t got);
            pixel_group_t want;
            if (expected_groups.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected group xl=%0d xr=%0d yu=%0d yl=%0d pix=%0b span=%0b last=%0b",
                             got.x_left, got.x_right, got.y_upper, got.y_lower,
                             got.pixel_value, got.is_span, got.last);
                return;
            end
            want = expected_groups.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: group mismatch at %0t", $realtime);
                    $display("  expected xl=%0d xr=%0d yu=%0d yl=%0d pix=%0b span=%0b last=%0b",
                             want.x_left, want.x_right, want.y_upper, want.y_lower,
                             want.pixel_value, want.is_span, want.last);
                    $display("  actual   xl=%0d xr=%0d yu=%0d yl=%0d pix=%0b span=%0b last=%0b",
                             got.x_left, got.x_right, got.y_upper, got.y_lower,
                             got.pixel_value, got.is_span, got.last);
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [COORD_BITS-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_start_req;
    logic [COORD_BITS-1:0] s_corner_x;
    logic [COORD_BITS-1:0] s_corner_y;
    logic                  s_pen_set;
    logic                  m_valid;
    logic                  m_ready;
    coord_t                m_x_left;
    coord_t                m_x_right;
    coord_t                m_y_upper;
    coord_t                m_y_lower;
    logic                  m_pixel_value;
    logic                  m_is_span;
    logic                  m_last;

    ellipse_scoreboard sb;
    bit                quiet_phase;
    int unsigned       words_sent;
    int unsigned       groups_seen;

    midpoint_ellipse_rasterizer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_req   (s_start_req),
        .s_corner_x    (s_corner_x),
        .s_corner_y    (s_corner_y),
        .s_pen_set     (s_pen_set),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_x_left      (m_x_left),
        .m_x_right     (m_x_right),
        .m_y_upper     (m_y_upper),
        .m_y_lower     (m_y_lower),
        .m_pixel_value (m_pixel_value),
        .m_is_span     (m_is_span),
        .m_last        (m_last)
    );

    always #2 aclk = ~aclk;

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic start, input logic [COORD_BITS-1:0] corner_x,
                             input logic [COORD_BITS-1:0] corner_y, input logic pen_in);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_req <= start;
        s_corner_x  <= corner_x;
        s_corner_y  <= corner_y;
        s_pen_set   <= pen_in;
        do @(posedge aclk); while (!s_ready);
        if (start || sb.running) words_sent++;
        sb.accept_word(start, corner_x, corner_y, pen_in);
        @(negedge aclk);
    endtask

    task automatic send_tick();
        send_word(1'b0, COORD_BITS'($urandom_range(0, COORD_MAX)),
                  COORD_BITS'($urandom_range(0, COORD_MAX)), 1'($urandom_range(0, 1)));
    endtask

    // Start word followed by ticks until the ellipse ends or the tick budget runs out.
    task automatic draw_ellipse(input logic [COORD_BITS-1:0] corner_x,
                                input logic [COORD_BITS-1:0] corner_y,
                                input logic pen_in, input int max_ticks);
        int n;
        n = 0;
        send_word(1'b1, corner_x, corner_y, pen_in);
        while (sb.running && n < max_ticks) begin
            send_tick();
            n++;
        end
    endtask

    // Drain all owed groups, then give a pending start set-up time to finish.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic reconfigure(input logic [2:0] which, input logic [COORD_BITS-1:0] cx,
                               input logic [COORD_BITS-1:0] cy, input logic fill);
        logic [COORD_BITS-1:0] value;
        cfg_index_t            index;
        settle();
        for (int i = 0; i < 3; i++) begin
            if (which[i]) begin
                index = cfg_index_t'(i);
                case (index)
                    REG_CENTER_X: value = cx;
                    REG_CENTER_Y: value = cy;
                    default:      value = {(COORD_BITS-1)'($urandom), fill};
                endcase
                cfg_valid <= 1'b1;
                cfg_index <= index;
                cfg_data  <= value;
                do @(posedge aclk); while (!cfg_ready);
                sb.write_register(index, value);
                @(negedge aclk);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return COORD_BITS'(COORD_MAX);
            default: return COORD_BITS'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    // A coordinate within spread of c, folded back into range at the borders.
    function automatic logic [COORD_BITS-1:0] near(logic [COORD_BITS-1:0] c, int spread);
        int v;
        v = int'(c) + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, spread));
        if (v < 0 || v > COORD_MAX) v = 2 * int'(c) - v;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return v[COORD_BITS-1:0];
    endfunction

    initial begin
        int choice;
        int size_pick;
        sb          = new();
        quiet_phase = 0;
        words_sent  = 0;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_CENTER_X;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_start_req = 1'b0;
        s_corner_x  = '0;
        s_corner_y  = '0;
        s_pen_set   = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A tick with nothing loaded is dropped.
        send_tick();
        // Corner on the center: both radii collapse to one.
        draw_ellipse('0, '0, 1'b1, RUN_TO_END);
        reconfigure(3'b111, COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 1'b1);
        // Widest radii from the far corner, then a new start cuts it short.
        draw_ellipse('0, '0, 1'b0, 3);
        draw_ellipse(COORD_BITS'(COORD_MAX - 2), COORD_BITS'(COORD_MAX), 1'b1, RUN_TO_END);
        reconfigure(3'b111, '0, '0, 1'b0);
        draw_ellipse(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 1'b1, 2);
        // Fill mode flipped while an ellipse is half drawn.
        reconfigure(3'b011, 12'd2000, 12'd1000, 1'b0);
        draw_ellipse(12'd2006, 12'd1003, 1'b0, 3);
        reconfigure(3'b100, '0, '0, 1'b1);
        while (sb.running) send_tick();

        while (words_sent < WORD_TARGET) begin
            choice = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) quiet_phase = !quiet_phase;
            if (choice < 8) begin
                reconfigure(3'($urandom_range(1, 7)), pick_coord(), pick_coord(),
                            1'($urandom_range(0, 1)));
            end else if (choice < 14 && !sb.running) begin
                repeat ($urandom_range(1, 3)) send_tick();
            end else if (sb.running && choice < 50) begin
                // Large ellipses are only walked in bounded stretches.
                for (int k = 0; k < 300 && sb.running; k++) send_tick();
            end else begin
                size_pick = $urandom_range(0, 99);
                if (size_pick < 4)
                    draw_ellipse(COORD_BITS'($urandom_range(0, COORD_MAX)),
                                 COORD_BITS'($urandom_range(0, COORD_MAX)),
                                 1'($urandom_range(0, 1)), $urandom_range(0, 40));
                else if (size_pick < 9)
                    draw_ellipse(near(sb.center_x, 60), near(sb.center_y, 60),
                                 1'($urandom_range(0, 1)), $urandom_range(0, 150));
                else
                    draw_ellipse(near(sb.center_x, 16), near(sb.center_y, 16),
                                 1'($urandom_range(0, 1)),
                                 ($urandom_range(0, 99) < 15) ? $urandom_range(0, 20)
                                                              : RUN_TO_END);
            end
        end

        settle();
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : receiver
        int           gap;
        bit           held_off;
        pixel_group_t got;
        held_off    = 0;
        groups_seen = 0;
        m_ready     = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            // One long hold-off so the block backs up into its input.
            if (!held_off && groups_seen >= 200) begin
                held_off = 1;
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            gap = quiet_phase ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.x_left      = m_x_left;
            got.x_right     = m_x_right;
            got.y_upper     = m_y_upper;
            got.y_lower     = m_y_lower;
            got.pixel_value = m_pixel_value;
            got.is_span     = m_is_span;
            got.last        = m_last;
            sb.compare_group(got);
            groups_seen++;
            @(negedge aclk);
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
